[design/grc_pkg.sv]
// Shared types, codes and the tangent table of the grid ray caster.
// No dependencies; used by grc_controller, grc_datapath, grid_ray_caster and the dv files.
package grc_pkg;

    // Request and result transactions
    typedef struct packed {
        logic        req_type;
        logic [11:0] cell_index;
        logic [7:0]  cell_value;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [11:0] ray_angle;
    } t_req;

    typedef struct packed {
        logic [15:0] hit_x;
        logic [15:0] hit_y;
        logic [16:0] distance;
        logic [1:0]  side;
    } t_res;

    localparam logic       REQ_WRITE  = 1'b0;
    localparam logic       REQ_CAST   = 1'b1;
    localparam logic [1:0] SIDE_HORIZ = 2'd0;
    localparam logic [1:0] SIDE_VERT  = 2'd1;
    localparam logic [1:0] SIDE_NONE  = 2'd2;

    localparam logic       CFG_MAP_WIDTH  = 1'b0;
    localparam logic       CFG_CELL_COUNT = 1'b1;
    localparam logic [6:0]  WIDTH_RST = 7'd64;
    localparam logic [12:0] COUNT_RST = 13'd4096;
    localparam logic [16:0] DIST_MAX  = 17'd131071;

    // Controller to datapath commands
    typedef struct packed {
        logic clr;
        logic wr;
        logic load;
        logic vert;
        logic tbl;
        logic init;
        logic mul;
        logic addr;
        logic adv;
        logic take;
        logic sq;
        logic acc;
        logic pick;
        logic root;
        logic emit;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic clr_last;
        logic skip;
        logic cell_hit;
        logic last_step;
        logic root_last;
    } t_sts;

    localparam int ANGLE_Q30 = 1647099;

    typedef logic [26:0] t_tan_tbl [1024];

    // Restoring long division; only evaluated while the table is built
    function automatic logic [63:0] udiv(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] rem;
        q   = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem  = rem - {1'b0, den};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [63:0] oct_sin(input int j);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        longint      sum;
        x    = 64'(j) * 64'(ANGLE_Q30);
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        for (int n = 1; n <= 5; n++) begin
            term = udiv((term * x2) >> 30, 64'((2 * n) * (2 * n + 1)));
            sum  = n[0] ? sum - longint'(term) : sum + longint'(term);
        end
        return (sum > 0) ? 64'(sum) : 64'd0;
    endfunction

    function automatic logic [63:0] oct_cos(input int j);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        longint      sum;
        x    = 64'(j) * 64'(ANGLE_Q30);
        x2   = (x * x) >> 30;
        term = 64'd1 << 30;
        sum  = longint'(term);
        for (int n = 1; n <= 6; n++) begin
            term = udiv((term * x2) >> 30, 64'((2 * n - 1) * (2 * n)));
            sum  = n[0] ? sum - longint'(term) : sum + longint'(term);
        end
        return (sum > 0) ? 64'(sum) : 64'd0;
    endfunction

    // |tan| of first-quadrant angles 0..1023, unsigned Q11.16, evaluated at elaboration
    function automatic t_tan_tbl build_tan_tbl();
        t_tan_tbl    t;
        logic [63:0] s;
        logic [63:0] c;
        logic [63:0] q;
        for (int j = 0; j < 1024; j++) begin
            if (j <= 512) begin
                s = oct_sin(j);
                c = oct_cos(j);
                q = (c == 64'd0) ? 64'h7FFF_FFFF : udiv(s << 16, c);
            end else begin
                s = oct_sin(1024 - j);
                c = oct_cos(1024 - j);
                q = (s == 64'd0) ? 64'h7FFF_FFFF : udiv(c << 16, s);
            end
            t[j] = q[26:0];
        end
        return t;
    endfunction

    localparam t_tan_tbl TAN_TBL = build_tan_tbl();

endpackage

[design/grc_controller.sv]
// Sequencer of the grid ray caster: clearing pass, two grid walks, root, emit.
// Depends on grc_pkg (t_cmd, t_sts, t_req, request codes).
module grc_controller (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  grc_pkg::t_req i_req,
    input  grc_pkg::t_sts i_sts,
    output grc_pkg::t_cmd o_cmd,
    output logic          busy
);

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_TBL  = 4'd2;
    localparam logic [3:0] S_INIT = 4'd3;
    localparam logic [3:0] S_MUL  = 4'd4;
    localparam logic [3:0] S_ADDR = 4'd5;
    localparam logic [3:0] S_CHK  = 4'd6;
    localparam logic [3:0] S_SQ   = 4'd7;
    localparam logic [3:0] S_ACC  = 4'd8;
    localparam logic [3:0] S_PICK = 4'd9;
    localparam logic [3:0] S_ROOT = 4'd10;
    localparam logic [3:0] S_EMIT = 4'd11;

    logic [3:0] r_state, n_state;
    logic       r_vert, n_vert;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_vert  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_vert  <= n_vert;
        end
    end

    always_comb begin
        n_state = r_state;
        n_vert  = r_vert;
        o_cmd   = '0;
        o_cmd.vert = r_vert;
        case (r_state)
            S_CLR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (start) begin
                    if (i_req.req_type == grc_pkg::REQ_CAST) begin
                        o_cmd.load = 1'b1;
                        n_vert  = 1'b0;
                        n_state = S_TBL;
                    end else begin
                        o_cmd.wr = 1'b1;
                    end
                end
            end
            S_TBL: begin
                o_cmd.tbl = 1'b1;
                n_state   = S_INIT;
            end
            S_INIT: begin
                o_cmd.init = 1'b1;
                if (!i_sts.skip) n_state = S_MUL;
                else if (!r_vert) begin
                    n_vert  = 1'b1;
                    n_state = S_TBL;
                end else n_state = S_PICK;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_ADDR;
            end
            S_ADDR: begin
                o_cmd.addr = 1'b1;
                n_state    = S_CHK;
            end
            S_CHK: begin
                if (i_sts.cell_hit) begin
                    o_cmd.take = 1'b1;
                    n_state    = S_SQ;
                end else if (!i_sts.last_step) begin
                    o_cmd.adv = 1'b1;
                    n_state   = S_MUL;
                end else if (!r_vert) begin
                    n_vert  = 1'b1;
                    n_state = S_TBL;
                end else n_state = S_PICK;
            end
            S_SQ: begin
                o_cmd.sq = 1'b1;
                n_state  = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                if (!r_vert) begin
                    n_vert  = 1'b1;
                    n_state = S_TBL;
                end else n_state = S_PICK;
            end
            S_PICK: begin
                o_cmd.pick = 1'b1;
                n_state    = S_ROOT;
            end
            S_ROOT: begin
                o_cmd.root = 1'b1;
                if (i_sts.root_last) n_state = S_EMIT;
            end
            S_EMIT: begin
                o_cmd.emit = 1'b1;
                n_state    = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign busy = (r_state != S_IDLE);

endmodule

[design/grc_datapath.sv]
// Datapath of the grid ray caster: map memory, tangent lookup, walk step,
// distance squares and bit-serial square root. Depends on grc_pkg.
module grc_datapath #(
    parameter int MAP_SIDE  = 64,
    parameter int MAX_STEPS = 20
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  grc_pkg::t_cmd i_cmd,
    output grc_pkg::t_sts o_sts,
    input  grc_pkg::t_req i_req,
    input  logic          i_cfg_we,
    input  logic          i_cfg_index,
    input  logic [12:0]   i_cfg_wdata,
    output logic          o_valid,
    output grc_pkg::t_res o_res
);

    localparam int KW = $clog2(MAX_STEPS + 1);

    logic [7:0]  mem [4096];
    logic [6:0]  r_width;
    logic [12:0] r_cell_cnt;
    logic [11:0] r_clr_addr;

    logic [15:0] r_px, r_py;
    logic [11:0] r_ang;
    logic [26:0] r_tbl_q;
    logic signed [27:0] r_slope;
    logic signed [18:0] r_m;
    logic        r_back;
    logic [KW-1:0] r_k;
    logic signed [46:0] r_prod;
    logic [7:0]  r_rd_q;
    logic        r_in_map;
    logic [15:0] r_cand_x, r_cand_y;
    logic [15:0] r_hx, r_hy, r_vx, r_vy;
    logic        r_hh, r_vh;
    logic [31:0] r_sqx, r_sqy;
    logic [32:0] r_dh, r_dv;
    logic [15:0] r_ox, r_oy;
    logic [1:0]  r_side;
    logic [33:0] r_rad, r_res, r_bit;
    logic        r_out_valid;
    grc_pkg::t_res r_out;

    // angle decode
    logic [10:0] rng;
    logic        neg, skip, back;
    logic [11:0] tidx;
    logic [15:0] pmain, pother;

    always_comb begin
        rng = r_ang[10:0];
        neg = (rng > 11'd1024);
        if (i_cmd.vert) begin
            tidx = neg ? (12'd2048 - {1'b0, rng}) : {1'b0, rng};
            skip = (rng == 11'd1024);
            back = (r_ang > 12'd1024) && (r_ang < 12'd3072);
            pmain  = r_px;
            pother = r_py;
        end else begin
            tidx = neg ? ({1'b0, rng} - 12'd1024) : (12'd1024 - {1'b0, rng});
            skip = (rng == 11'd0);
            back = r_ang[11];
            pmain  = r_py;
            pother = r_px;
        end
    end

    // crossing point and map index
    logic signed [18:0] dmain;
    logic signed [46:0] rnd;
    logic signed [32:0] other, mm, cx_full, cy_full;
    logic [12:0] row_base;
    logic [13:0] idx;
    logic        in_map;

    always_comb begin
        dmain   = r_m - $signed({3'b0, pmain});
        rnd     = r_prod + 47'sd32768;
        other   = $signed({17'b0, pother}) + {{2{rnd[46]}}, rnd[46:16]};
        mm      = {{14{r_m[18]}}, r_m};
        cx_full = i_cmd.vert ? mm : other;
        cy_full = i_cmd.vert ? other : mm;
        row_base = 13'({7'b0, cy_full[15:10]} * {6'b0, r_width});
        idx      = {1'b0, row_base} + {8'b0, cx_full[15:10]};
        in_map   = !cx_full[32] && !cy_full[32]
                && (cx_full[32:10] < 23'(MAP_SIDE)) && (cy_full[32:10] < 23'(MAP_SIDE))
                && ({1'b0, cx_full[15:10]} < r_width)
                && (idx < {1'b0, r_cell_cnt}) && (idx[13:12] == 2'b00);
    end

    logic signed [16:0] dx, dy;
    logic signed [33:0] sqx_full, sqy_full;
    logic [33:0] trial;

    always_comb begin
        dx = $signed({1'b0, r_cand_x}) - $signed({1'b0, r_px});
        dy = $signed({1'b0, r_cand_y}) - $signed({1'b0, r_py});
        sqx_full = dx * dx;
        sqy_full = dy * dy;
        trial    = r_res + r_bit;
    end

    // configuration, clear pointer and output strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width     <= grc_pkg::WIDTH_RST;
            r_cell_cnt  <= grc_pkg::COUNT_RST;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    grc_pkg::CFG_MAP_WIDTH:  r_width    <= i_cfg_wdata[6:0];
                    grc_pkg::CFG_CELL_COUNT: r_cell_cnt <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_cmd.clr) r_clr_addr <= r_clr_addr + 12'd1;
            r_out_valid <= i_cmd.emit;
        end
    end

    // map memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) mem[r_clr_addr] <= 8'd0;
        else if (i_cmd.wr) mem[i_req.cell_index] <= i_req.cell_value;
        if (i_cmd.addr) r_rd_q <= mem[idx[11:0]];
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_px  <= i_req.pos_x;
            r_py  <= i_req.pos_y;
            r_ang <= i_req.ray_angle;
            r_hh  <= 1'b0;
            r_vh  <= 1'b0;
        end
        if (i_cmd.tbl) r_tbl_q <= grc_pkg::TAN_TBL[tidx[9:0]];
        if (i_cmd.init) begin
            r_slope <= neg ? -$signed({1'b0, r_tbl_q}) : $signed({1'b0, r_tbl_q});
            r_m     <= back ? $signed({3'b0, pmain[15:10], 10'b0}) - 19'sd1
                            : $signed({3'b0, pmain[15:10], 10'b0}) + 19'sd1024;
            r_back  <= back;
            r_k     <= '0;
        end
        if (i_cmd.mul) r_prod <= dmain * r_slope;
        if (i_cmd.addr) begin
            r_in_map <= in_map;
            r_cand_x <= cx_full[15:0];
            r_cand_y <= cy_full[15:0];
        end
        if (i_cmd.adv) begin
            r_k <= r_k + KW'(1);
            r_m <= r_back ? r_m - 19'sd1024 : r_m + 19'sd1024;
        end
        if (i_cmd.take) begin
            if (i_cmd.vert) begin
                r_vx <= r_cand_x;
                r_vy <= r_cand_y;
                r_vh <= 1'b1;
            end else begin
                r_hx <= r_cand_x;
                r_hy <= r_cand_y;
                r_hh <= 1'b1;
            end
        end
        if (i_cmd.sq) begin
            r_sqx <= sqx_full[31:0];
            r_sqy <= sqy_full[31:0];
        end
        if (i_cmd.acc) begin
            if (i_cmd.vert) r_dv <= {1'b0, r_sqx} + {1'b0, r_sqy};
            else            r_dh <= {1'b0, r_sqx} + {1'b0, r_sqy};
        end
        if (i_cmd.pick) begin
            if (r_vh && (!r_hh || r_dv < r_dh)) begin
                r_ox <= r_vx;  r_oy <= r_vy;
                r_side <= grc_pkg::SIDE_VERT;
                r_rad  <= {1'b0, r_dv};
            end else if (r_hh && (!r_vh || r_dh < r_dv)) begin
                r_ox <= r_hx;  r_oy <= r_hy;
                r_side <= grc_pkg::SIDE_HORIZ;
                r_rad  <= {1'b0, r_dh};
            end else begin
                r_ox <= r_px;  r_oy <= r_py;
                r_side <= grc_pkg::SIDE_NONE;
                r_rad  <= '0;
            end
            r_res <= '0;
            r_bit <= 34'h1_0000_0000;
        end
        if (i_cmd.root) begin
            if (r_rad >= trial) begin
                r_rad <= r_rad - trial;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
        if (i_cmd.emit) begin
            r_out.hit_x    <= r_ox;
            r_out.hit_y    <= r_oy;
            r_out.distance <= (r_res > {17'b0, grc_pkg::DIST_MAX}) ? grc_pkg::DIST_MAX
                                                                   : r_res[16:0];
            r_out.side     <= r_side;
        end
    end

    always_comb begin
        o_sts.clr_last  = &r_clr_addr;
        o_sts.skip      = skip;
        o_sts.cell_hit  = r_in_map && (r_rd_q != 8'd0);
        o_sts.last_step = (r_k == KW'(MAX_STEPS - 1));
        o_sts.root_last = r_bit[0];
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_out;

endmodule

[design/grid_ray_caster.sv]
// Grid ray caster: a write transaction gives no result; a cast is bounded by the
// multiply, index and map-read loop per crossing (S_MUL, S_ADDR, S_CHK, up to MAX_STEPS
// crossings per walk) and a 17-step root. One transaction at a time; busy drops in the
// result strobe's cycle. After reset a clearing pass zeroes the 4096-cell map, one cell
// a cycle, with busy high; configuration writes are taken throughout. Results cannot
// be stalled.
module grid_ray_caster #(
    parameter int MAP_SIDE  = 64,
    parameter int MAX_STEPS = 20
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  grc_pkg::t_req i_req,
    output logic          o_valid,
    output grc_pkg::t_res o_res,
    input  logic          i_cfg_we,
    input  logic          i_cfg_index,
    input  logic [12:0]   i_cfg_wdata
);

    grc_pkg::t_cmd cmd;
    grc_pkg::t_sts sts;

    // Sequence the walks: clear, look up slope, step crossings, square, root, emit
    grc_controller u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_req   (i_req),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .busy    (busy)
    );

    // Hold the map, the walk registers and the result transaction
    grc_datapath #(
        .MAP_SIDE  (MAP_SIDE),
        .MAX_STEPS (MAX_STEPS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_req       (i_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_valid     (o_valid),
        .o_res       (o_res)
    );

endmodule

[dv/grid_ray_caster_checker.sv]
// Checker for the grid ray caster: watches requests, configuration writes and results,
// predicts each cast and compares it field by field. Depends on grc_pkg.
`timescale 1ns / 100ps
module grid_ray_caster_checker #(
    parameter int MAP_SIDE  = 64,
    parameter int MAX_STEPS = 20
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_busy,
    input  grc_pkg::t_req i_req,
    input  logic          i_valid,
    input  grc_pkg::t_res i_res,
    input  logic          i_cfg_we,
    input  logic          i_cfg_index,
    input  logic [12:0]   i_cfg_wdata,
    output int            o_errors,
    output int            o_pending
);

    localparam longint unsigned ANG_UNIT = 64'd1647099;
    localparam longint          TAN_BIG  = 64'h7FFF_FFFF;

    logic [7:0]    tile_map [4096];
    logic [6:0]    row_width;
    logic [12:0]   cell_limit;
    grc_pkg::t_res expected_hits [$];

    function automatic void octant_trig(input int j, output longint unsigned s,
                                        output longint unsigned c);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          acc;
        x    = longint'(j) * ANG_UNIT;
        x2   = (x * x) >> 30;
        term = x;
        acc  = longint'(x);
        for (int n = 1; n <= 5; n++) begin
            term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
            acc  = (n % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
        end
        s    = (acc > 0) ? acc : 0;
        term = 64'd1 << 30;
        acc  = longint'(term);
        for (int n = 1; n <= 6; n++) begin
            term = ((term * x2) >> 30) / longint'((2 * n - 1) * (2 * n));
            acc  = (n % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
        end
        c = (acc > 0) ? acc : 0;
    endfunction

    // |tan| of a first-quadrant angle, Q16.16
    function automatic longint slope_mag(input int j);
        longint unsigned s;
        longint unsigned c;
        if (j >= 1024) return TAN_BIG;
        if (j <= 512) begin
            octant_trig(j, s, c);
            return (c == 0) ? TAN_BIG : longint'((s << 16) / c);
        end
        octant_trig(1024 - j, s, c);
        return (s == 0) ? TAN_BIG : longint'((c << 16) / s);
    endfunction

    function automatic bit wall_at(input longint x, input longint y);
        longint cx;
        longint cy;
        longint idx;
        if (x < 0 || y < 0) return 1'b0;
        cx = x >>> 10;
        cy = y >>> 10;
        if (cx >= row_width || cx >= MAP_SIDE || cy >= MAP_SIDE) return 1'b0;
        idx = cy * row_width + cx;
        if (idx >= cell_limit || idx >= 4096) return 1'b0;
        return tile_map[idx] != 8'd0;
    endfunction

    // Step across grid lines on one axis; y is the main axis when horiz
    function automatic bit grid_walk(input bit horiz, input longint px, input longint py,
                                     input longint first, input longint stp,
                                     input longint slope, output longint hx,
                                     output longint hy);
        longint m;
        longint x;
        longint y;
        hx = 0;
        hy = 0;
        for (int k = 0; k < MAX_STEPS; k++) begin
            m = first + k * stp;
            if (horiz) begin
                y = m;
                x = px + (((m - py) * slope + 32768) >>> 16);
            end else begin
                x = m;
                y = py + (((m - px) * slope + 32768) >>> 16);
            end
            if (wall_at(x, y)) begin
                hx = x;
                hy = y;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic longint unsigned floor_root(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic grc_pkg::t_res cast_ray(input grc_pkg::t_req q);
        longint          px;
        longint          py;
        longint          hx;
        longint          hy;
        longint          vx;
        longint          vy;
        longint          base;
        longint          sl;
        int              a;
        int              r;
        bit              h_hit;
        bit              v_hit;
        longint unsigned dh;
        longint unsigned dv;
        longint unsigned d;
        grc_pkg::t_res   o;
        px    = q.pos_x;
        py    = q.pos_y;
        a     = q.ray_angle;
        r     = a % 2048;
        h_hit = 1'b0;
        v_hit = 1'b0;
        dh    = 0;
        dv    = 0;
        if (r != 0) begin
            sl   = (r <= 1024) ? slope_mag(1024 - r) : -slope_mag(r - 1024);
            base = py & ~longint'(1023);
            if (a > 2048) h_hit = grid_walk(1'b1, px, py, base - 1, -1024, sl, hx, hy);
            else          h_hit = grid_walk(1'b1, px, py, base + 1024, 1024, sl, hx, hy);
        end
        if (r != 1024) begin
            sl   = (r <= 1024) ? slope_mag(r) : -slope_mag(2048 - r);
            base = px & ~longint'(1023);
            if (a > 1024 && a < 3072)
                v_hit = grid_walk(1'b0, px, py, base - 1, -1024, sl, vx, vy);
            else
                v_hit = grid_walk(1'b0, px, py, base + 1024, 1024, sl, vx, vy);
        end
        if (h_hit) dh = (hx - px) * (hx - px) + (hy - py) * (hy - py);
        if (v_hit) dv = (vx - px) * (vx - px) + (vy - py) * (vy - py);
        if (v_hit && (!h_hit || dv < dh)) begin
            o.hit_x = vx[15:0];
            o.hit_y = vy[15:0];
            o.side  = grc_pkg::SIDE_VERT;
            d       = dv;
        end else if (h_hit && (!v_hit || dh < dv)) begin
            o.hit_x = hx[15:0];
            o.hit_y = hy[15:0];
            o.side  = grc_pkg::SIDE_HORIZ;
            d       = dh;
        end else begin
            o.hit_x = q.pos_x;
            o.hit_y = q.pos_y;
            o.side  = grc_pkg::SIDE_NONE;
            d       = 0;
        end
        d = floor_root(d);
        o.distance = (d > grc_pkg::DIST_MAX) ? grc_pkg::DIST_MAX : d[16:0];
        return o;
    endfunction

    always @(posedge i_clk) begin
        grc_pkg::t_res want;
        if (!i_rst_n) begin
            foreach (tile_map[i]) tile_map[i] = 8'd0;
            row_width  = grc_pkg::WIDTH_RST;
            cell_limit = grc_pkg::COUNT_RST;
            expected_hits.delete();
            o_errors = 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == grc_pkg::CFG_MAP_WIDTH) row_width = i_cfg_wdata[6:0];
                else                                       cell_limit = i_cfg_wdata;
            end
            if (i_start && !i_busy) begin
                if (i_req.req_type == grc_pkg::REQ_WRITE)
                    tile_map[i_req.cell_index] = i_req.cell_value;
                else
                    expected_hits.push_back(cast_ray(i_req));
            end
            if (i_valid) begin
                if (expected_hits.size() == 0) begin
                    $error("unexpected result transaction: hit_x %0d hit_y %0d",
                           i_res.hit_x, i_res.hit_y);
                    o_errors++;
                end else begin
                    want = expected_hits.pop_front();
                    if (i_res.hit_x !== want.hit_x) begin
                        $error("hit_x: expected %0d, got %0d", want.hit_x, i_res.hit_x);
                        o_errors++;
                    end
                    if (i_res.hit_y !== want.hit_y) begin
                        $error("hit_y: expected %0d, got %0d", want.hit_y, i_res.hit_y);
                        o_errors++;
                    end
                    if (i_res.distance !== want.distance) begin
                        $error("distance: expected %0d, got %0d", want.distance,
                               i_res.distance);
                        o_errors++;
                    end
                    if (i_res.side !== want.side) begin
                        $error("side: expected %0d, got %0d", want.side, i_res.side);
                        o_errors++;
                    end
                end
            end
        end
        o_pending = expected_hits.size();
    end

endmodule

[dv/grid_ray_caster_tb.sv]
// Testbench top for the grid ray caster: clock, reset, stimulus and verdict.
// Depends on grc_pkg, grid_ray_caster and grid_ray_caster_checker.
`timescale 1ns / 100ps
module grid_ray_caster_tb;

    // Cycles with no transaction and no result before the run is abandoned; covers the
    // clearing pass and the longest cast many times over.
    localparam int IDLE_LIMIT = 20000;
    localparam int RANDOM_ITEMS = 1030;

    logic          i_clk;
    logic          i_rst_n;
    logic          start;
    logic          busy;
    grc_pkg::t_req i_req;
    logic          o_valid;
    grc_pkg::t_res o_res;
    logic          i_cfg_we;
    logic          i_cfg_index;
    logic [12:0]   i_cfg_wdata;
    int            mismatches;
    int            casts_pending;
    int            quiet_cycles;
    int            gap_percent;
    int            cur_width;

    grid_ray_caster dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_req      (i_req),
        .o_valid    (o_valid),
        .o_res      (o_res),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_wdata(i_cfg_wdata)
    );

    grid_ray_caster_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_busy     (busy),
        .i_req      (i_req),
        .i_valid    (o_valid),
        .i_res      (o_res),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_wdata(i_cfg_wdata),
        .o_errors   (mismatches),
        .o_pending  (casts_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Watchdog: count cycles in which neither a transaction nor a result moves
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // Hold start low for a random number of cycles according to the current gap rate,
    // then present the transaction and wait until the block takes it. Start stays high
    // afterwards so that back-to-back transactions need no second assignment.
    task automatic issue(input grc_pkg::t_req q);
        while ($urandom_range(0, 99) < gap_percent) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        i_req <= q;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
    endtask

    // Drop start and wait for every outstanding cast, then let any write settle
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (casts_pending != 0) @(posedge i_clk);
        repeat (160) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [12:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == grc_pkg::CFG_MAP_WIDTH) cur_width = val[6:0];
    endtask

    function automatic grc_pkg::t_req tile_write(input int idx, input int val);
        grc_pkg::t_req q;
        q            = 65'({$urandom, $urandom, $urandom});
        q.req_type   = grc_pkg::REQ_WRITE;
        q.cell_index = idx[11:0];
        q.cell_value = val[7:0];
        return q;
    endfunction

    function automatic grc_pkg::t_req ray(input int x, input int y, input int ang);
        grc_pkg::t_req q;
        q           = 65'({$urandom, $urandom, $urandom});
        q.req_type  = grc_pkg::REQ_CAST;
        q.pos_x     = x[15:0];
        q.pos_y     = y[15:0];
        q.ray_angle = ang[11:0];
        return q;
    endfunction

    // Random transaction: writes clustered in the top-left corner so that walls are
    // dense where most rays start; the rest spread over every field value
    function automatic grc_pkg::t_req random_item();
        int            idx;
        int            val;
        int            ang;
        grc_pkg::t_req q;
        if ($urandom_range(0, 99) < 35) begin
            if ($urandom_range(0, 99) < 75)
                idx = $urandom_range(0, 15) * cur_width + $urandom_range(0, 15);
            else
                idx = $urandom_range(0, 4095);
            val = ($urandom_range(0, 99) < 30) ? 0 : $urandom_range(1, 255);
            return tile_write(idx, val);
        end
        case ($urandom_range(0, 5))
            0:       ang = $urandom_range(0, 3) * 1024;
            1:       ang = ($urandom_range(0, 3) * 1024 + $urandom_range(0, 4) - 2) & 4095;
            default: ang = $urandom_range(0, 4095);
        endcase
        if ($urandom_range(0, 99) < 75)
            q = ray($urandom_range(0, 16383), $urandom_range(0, 16383), ang);
        else
            q = ray($urandom_range(0, 65535), $urandom_range(0, 65535), ang);
        return q;
    endfunction

    initial begin
        int wd [7];
        int cc [7];
        int per_phase;
        wd = '{64, 1, 16, 64, 0, 127, 33};
        cc = '{4096, 1, 256, 4095, 100, 8191, 2000};
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_req       = '0;
        i_cfg_we    = 1'b0;
        i_cfg_index = grc_pkg::CFG_MAP_WIDTH;
        i_cfg_wdata = '0;
        gap_percent = 16;
        cur_width   = 64;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: corner and edge walls, quarter angles, extreme origins
        write_reg(grc_pkg::CFG_MAP_WIDTH, 13'd64);
        write_reg(grc_pkg::CFG_CELL_COUNT, 13'd4096);
        issue(tile_write(0, 255));
        issue(tile_write(4095, 1));
        issue(tile_write(5 * 64 + 5, 7));
        issue(tile_write(5 * 64 + 9, 200));
        issue(tile_write(9 * 64 + 5, 9));
        issue(tile_write(1 * 64 + 5, 3));
        issue(tile_write(5 * 64 + 1, 4));
        issue(ray(5 * 1024 + 512, 7 * 1024, 3072));
        issue(ray(7 * 1024 + 512, 5 * 1024 + 512, 2048));
        issue(ray(3 * 1024 + 512, 5 * 1024 + 512, 0));
        issue(ray(5 * 1024 + 512, 3 * 1024, 1024));
        issue(ray(3 * 1024, 3 * 1024, 512));
        issue(ray(7 * 1024, 7 * 1024, 2560));
        issue(ray(0, 0, 1));
        issue(ray(65535, 65535, 4095));
        issue(ray(65535, 0, 1536));
        issue(ray(0, 65535, 3584));
        issue(ray(63 * 1024 + 1023, 63 * 1024 + 1023, 2560));
        issue(ray(5 * 1024 + 1023, 7 * 1024, 3071));
        issue(ray(2 * 1024, 5 * 1024 + 512, 2047));
        issue(ray(1024, 1024, 2049));
        issue(tile_write(5 * 64 + 5, 0));
        issue(ray(5 * 1024 + 512, 7 * 1024, 3072));
        drain();

        // Random phases: sender gap rate changes after each third of the items, registers every phase
        per_phase = RANDOM_ITEMS / 7;
        for (int ph = 0; ph < 7; ph++) begin
            write_reg(grc_pkg::CFG_MAP_WIDTH, wd[ph][12:0]);
            write_reg(grc_pkg::CFG_CELL_COUNT, cc[ph][12:0]);
            for (int n = 0; n < per_phase; n++) begin
                int done;
                done = ph * per_phase + n;
                gap_percent = (done < RANDOM_ITEMS / 3) ? 16 :
                              (done < 2 * RANDOM_ITEMS / 3) ? 71 : 0;
                issue(random_item());
            end
            drain();
        end

        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

[sim.f]
design/grc_pkg.sv
design/grc_controller.sv
design/grc_datapath.sv
design/grid_ray_caster.sv
dv/grid_ray_caster_checker.sv
dv/grid_ray_caster_tb.sv
